// ===== rtl/jsu_pkg.sv =====
// Shared types and result codes for the JSON string unescaper.
package jsu_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int CP_W   = 21;

  localparam logic [3:0] KIND_BYTE       = 4'd0;
  localparam logic [3:0] KIND_DONE       = 4'd1;
  localparam logic [3:0] KIND_UNTERM     = 4'd2;
  localparam logic [3:0] KIND_CTRL       = 4'd3;
  localparam logic [3:0] KIND_BADESC     = 4'd4;
  localparam logic [3:0] KIND_UNTERM_HEX = 4'd5;
  localparam logic [3:0] KIND_BADHEX     = 4'd6;
  localparam logic [3:0] KIND_LONE       = 4'd7;
  localparam logic [3:0] KIND_BADPAIR    = 4'd8;
  localparam logic [3:0] KIND_NOTSTR     = 4'd9;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } jsu_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] result_kind;
    logic       last_of_run;
  } jsu_result_t;

  // One job per input that causes results: either a single beat
  // (a raw byte or a status kind) or a code point to encode as UTF-8.
  typedef struct packed {
    logic            utf8;
    logic [3:0]      kind;
    logic [CP_W-1:0] data;
  } jsu_job_t;

endpackage

// ===== rtl/json_string_unescape.sv =====
// Top level of the JSON string literal decoder with UTF-8 output.
// A result beat passes the job queue and then the output register before it is visible.
// Throughput: one input byte per cycle while the queue has room; the expander sends
// one beat per cycle unless stalled; a \u escape of two to four UTF-8 bytes holds it as long.
// A four-entry job queue lets the parser run ahead of the expander.
// Reset is synchronous; it empties the queue and the output and returns to idle.
module json_string_unescape import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  jsu_item_t   item,
  input  logic        pop,
  output logic        empty,
  output jsu_result_t result
);

  logic     accept;
  logic     job_valid;
  jsu_job_t job;
  jsu_job_t head;
  logic     q_empty;
  logic     q_pop;

  assign accept = push && !full;

  jsu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .job_valid (job_valid),
    .job       (job)
  );

  jsu_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (accept && job_valid),
    .push_job (job),
    .pop      (q_pop),
    .head     (head),
    .full     (full),
    .empty    (q_empty)
  );

  jsu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

// ===== rtl/jsu_front.sv =====
// Front end: parses input bytes and turns each one into at most one job.
module jsu_front import jsu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  jsu_item_t item,
  output logic      job_valid,
  output jsu_job_t  job
);

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_STR      = 3'd1;
  localparam logic [2:0] PH_ESC      = 3'd2;
  localparam logic [2:0] PH_HEX_A    = 3'd3;
  localparam logic [2:0] PH_WANT_BSL = 3'd4;
  localparam logic [2:0] PH_WANT_U   = 3'd5;
  localparam logic [2:0] PH_HEX_B    = 3'd6;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_N  = 8'h6E;
  localparam logic [7:0] CH_LC_R  = 8'h72;
  localparam logic [7:0] CH_LC_T  = 8'h74;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;

  logic [2:0]  phase, phase_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] code_accum, code_accum_next;
  logic [9:0]  high_half, high_half_next;

  logic [7:0]  c;
  logic        hex_ok;
  logic [3:0]  hex_digit;
  logic [15:0] acc_new;
  logic [10:0] plane;

  assign c       = item.text_byte;
  assign acc_new = {code_accum[11:0], hex_digit};
  assign plane   = {1'b0, high_half} + 11'd64;

  always_comb begin
    hex_ok    = 1'b1;
    hex_digit = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_digit = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      hex_digit = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      hex_digit = 4'(c - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    phase_next      = phase;
    hex_count_next  = hex_count;
    code_accum_next = code_accum;
    high_half_next  = high_half;
    job_valid       = 1'b0;
    job.utf8        = 1'b0;
    job.kind        = KIND_BYTE;
    job.data        = '0;
    unique case (phase) inside
      PH_IDLE: begin
        if (!item.text_end) begin
          if (c == CH_QUOTE) begin
            phase_next = PH_STR;
          end else begin
            job_valid = 1'b1;
            job.kind  = KIND_NOTSTR;
          end
        end
      end
      PH_STR: begin
        job_valid = 1'b1;
        if (item.text_end) begin
          job.kind   = KIND_UNTERM;
          phase_next = PH_IDLE;
        end else if (c == CH_QUOTE) begin
          job.kind   = KIND_DONE;
          phase_next = PH_IDLE;
        end else if (c < 8'h20) begin
          job.kind   = KIND_CTRL;
          phase_next = PH_IDLE;
        end else if (c == CH_BSL) begin
          job_valid  = 1'b0;
          phase_next = PH_ESC;
        end else begin
          job.data = CP_W'(c);
        end
      end
      PH_ESC: begin
        job_valid  = 1'b1;
        phase_next = PH_STR;
        if (item.text_end) begin
          job.kind   = KIND_UNTERM;
          phase_next = PH_IDLE;
        end else begin
          case (c) inside
            CH_QUOTE, CH_BSL, CH_SLASH: job.data = CP_W'(c);
            CH_LC_B: job.data = CP_W'(CH_BS);
            CH_LC_F: job.data = CP_W'(CH_FF);
            CH_LC_N: job.data = CP_W'(CH_LF);
            CH_LC_R: job.data = CP_W'(CH_CR);
            CH_LC_T: job.data = CP_W'(CH_TAB);
            CH_U: begin
              job_valid       = 1'b0;
              phase_next      = PH_HEX_A;
              hex_count_next  = 2'd0;
              code_accum_next = '0;
            end
            default: begin
              job.kind   = KIND_BADESC;
              phase_next = PH_IDLE;
            end
          endcase
        end
      end
      PH_HEX_A, PH_HEX_B: begin
        if (item.text_end) begin
          job_valid  = 1'b1;
          job.kind   = KIND_UNTERM_HEX;
          phase_next = PH_IDLE;
        end else if (!hex_ok) begin
          job_valid  = 1'b1;
          job.kind   = KIND_BADHEX;
          phase_next = PH_IDLE;
        end else begin
          code_accum_next = acc_new;
          if (hex_count != 2'd3) begin
            hex_count_next = hex_count + 2'd1;
          end else begin
            hex_count_next = 2'd0;
            if (phase == PH_HEX_A) begin
              if (acc_new[15:10] == 6'b110110) begin
                high_half_next = acc_new[9:0];
                phase_next     = PH_WANT_BSL;
              end else if (acc_new[15:10] == 6'b110111) begin
                job_valid  = 1'b1;
                job.kind   = KIND_LONE;
                phase_next = PH_IDLE;
              end else begin
                job_valid  = 1'b1;
                job.utf8   = 1'b1;
                job.data   = CP_W'(acc_new);
                phase_next = PH_STR;
              end
            end else begin
              job_valid = 1'b1;
              if (acc_new[15:10] != 6'b110111) begin
                job.kind   = KIND_BADPAIR;
                phase_next = PH_IDLE;
              end else begin
                job.utf8   = 1'b1;
                job.data   = {plane, acc_new[9:0]};
                phase_next = PH_STR;
              end
            end
          end
        end
      end
      PH_WANT_BSL: begin
        if (item.text_end || c != CH_BSL) begin
          job_valid  = 1'b1;
          job.kind   = KIND_LONE;
          phase_next = PH_IDLE;
        end else begin
          phase_next = PH_WANT_U;
        end
      end
      PH_WANT_U: begin
        if (item.text_end || c != CH_U) begin
          job_valid  = 1'b1;
          job.kind   = KIND_LONE;
          phase_next = PH_IDLE;
        end else begin
          phase_next      = PH_HEX_B;
          hex_count_next  = 2'd0;
          code_accum_next = '0;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      hex_count  <= 2'd0;
      code_accum <= '0;
      high_half  <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      hex_count  <= hex_count_next;
      code_accum <= code_accum_next;
      high_half  <= high_half_next;
    end
  end

endmodule

// ===== rtl/jsu_fifo.sv =====
// Short job queue between the parser and the byte expander.
module jsu_fifo import jsu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  jsu_job_t push_job,
  input  logic     pop,
  output jsu_job_t head,
  output logic     full,
  output logic     empty
);

  jsu_job_t          slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == (QPTR_W+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/jsu_back.sv =====
// Back end: expands queued jobs into result beats behind an output register.
module jsu_back import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  jsu_job_t    head,
  input  logic        q_empty,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output jsu_result_t result
);

  logic        out_valid;
  logic [1:0]  idx;
  logic [1:0]  last_idx;
  logic [1:0]  rem;
  logic        load;
  logic        advance;
  logic        at_last;
  jsu_result_t beat;
  logic [5:0]  cont;
  logic [CP_W-1:0] cp;

  assign cp = head.data;

  always_comb begin
    if (!head.utf8 || cp < CP_W'(21'h80)) begin
      last_idx = 2'd0;
    end else if (cp < CP_W'(21'h800)) begin
      last_idx = 2'd1;
    end else if (cp < CP_W'(21'h10000)) begin
      last_idx = 2'd2;
    end else begin
      last_idx = 2'd3;
    end
  end

  assign rem     = last_idx - idx;
  assign at_last = (idx == last_idx);

  always_comb begin
    case (rem)
      2'd0:    cont = cp[5:0];
      2'd1:    cont = cp[11:6];
      2'd2:    cont = cp[17:12];
      default: cont = {3'b000, cp[20:18]};
    endcase
  end

  always_comb begin
    beat.result_kind = head.kind;
    beat.last_of_run = at_last;
    beat.out_byte    = cp[7:0];
    if (head.utf8) begin
      if (idx != 2'd0) begin
        beat.out_byte = {2'b10, cont};
      end else begin
        case (last_idx)
          2'd0:    beat.out_byte = {1'b0, cp[6:0]};
          2'd1:    beat.out_byte = {3'b110, cp[10:6]};
          2'd2:    beat.out_byte = {4'b1110, cp[15:12]};
          default: beat.out_byte = {5'b11110, cp[20:18]};
        endcase
      end
    end
  end

  assign empty   = !out_valid;
  assign load    = !out_valid || pop;
  assign advance = !q_empty && load;
  assign q_pop   = advance && at_last;

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        idx       <= at_last ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/jsu_checker.sv =====
// Port-level checks for the JSON string decoder, bound to the top level.
module jsu_assertions import jsu_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        pop,
  input logic        empty,
  input jsu_result_t result
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("output not empty or input blocked after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(result))
    else $error("waiting result beat changed");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> result.result_kind <= KIND_NOTSTR)
    else $error("result kind out of range");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && result.result_kind != KIND_BYTE |-> result.out_byte == 8'd0)
    else $error("status beat carries a byte");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    !empty && result.result_kind != KIND_BYTE |-> result.last_of_run)
    else $error("status beat not last of its run");

endmodule

bind json_string_unescape jsu_assertions u_jsu_assertions (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .pop    (pop),
  .empty  (empty),
  .result (result)
);

// ===== sim/jsu_checker.sv =====
// Checker that predicts the decoded beats of the JSON string unescaper and compares them.
module jsu_checker import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  jsu_item_t   item,
  input  logic        pop,
  input  logic        empty,
  input  jsu_result_t result,
  output int unsigned fail_count,
  output int unsigned beats_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_LOWER_B   = 8'h62;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_U   = 8'h75;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_FF        = 8'h0C;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_TEXT,
    SCAN_ESCAPE,
    SCAN_HEX_FIRST,
    SCAN_WANT_BSL,
    SCAN_WANT_U,
    SCAN_HEX_SECOND
  } scan_state_t;

  scan_state_t scan_state;
  logic [1:0]  digit_count;
  logic [15:0] hex_accum;
  logic [9:0]  high_bits;
  jsu_result_t run_beats[$];
  jsu_result_t due_beats[$];

  function automatic void add_beat(logic [3:0] kind, logic [7:0] b);
    jsu_result_t beat;
    beat.out_byte    = b;
    beat.result_kind = kind;
    beat.last_of_run = 1'b0;
    run_beats = {run_beats, beat};
  endfunction

  function automatic void abort_string(logic [3:0] kind);
    scan_state = SCAN_IDLE;
    add_beat(kind, 8'h00);
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  function automatic void encode_utf8(logic [20:0] cp);
    if (cp < 21'h80) begin
      add_beat(KIND_BYTE, cp[7:0]);
    end else if (cp < 21'h800) begin
      add_beat(KIND_BYTE, {3'b110, cp[10:6]});
      add_beat(KIND_BYTE, {2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      add_beat(KIND_BYTE, {4'b1110, cp[15:12]});
      add_beat(KIND_BYTE, {2'b10, cp[11:6]});
      add_beat(KIND_BYTE, {2'b10, cp[5:0]});
    end else begin
      add_beat(KIND_BYTE, {5'b11110, cp[20:18]});
      add_beat(KIND_BYTE, {2'b10, cp[17:12]});
      add_beat(KIND_BYTE, {2'b10, cp[11:6]});
      add_beat(KIND_BYTE, {2'b10, cp[5:0]});
    end
    scan_state = SCAN_TEXT;
  endfunction

  function automatic void take_hex_digit(logic [7:0] c);
    int d;
    d = hex_digit(c);
    if (d < 0) begin
      abort_string(KIND_BADHEX);
      return;
    end
    hex_accum = {hex_accum[11:0], 4'(d)};
    if (digit_count != 2'd3) begin
      digit_count++;
      return;
    end
    digit_count = 2'd0;
    if (scan_state == SCAN_HEX_FIRST) begin
      if (hex_accum >= 16'hD800 && hex_accum <= 16'hDBFF) begin
        high_bits = 10'(hex_accum - 16'hD800);
        scan_state = SCAN_WANT_BSL;
      end else if (hex_accum >= 16'hDC00 && hex_accum <= 16'hDFFF) begin
        abort_string(KIND_LONE);
      end else begin
        encode_utf8({5'd0, hex_accum});
      end
    end else if (hex_accum < 16'hDC00 || hex_accum > 16'hDFFF) begin
      abort_string(KIND_BADPAIR);
    end else begin
      encode_utf8(21'h10000 + {1'b0, high_bits, 10'd0} + 21'(hex_accum - 16'hDC00));
    end
  endfunction

  function automatic void decode_text_byte(jsu_item_t it);
    logic [7:0] c;
    logic       fin;
    c = it.text_byte;
    fin = it.text_end;
    run_beats.delete();
    case (scan_state) inside
      SCAN_IDLE: begin
        if (!fin) begin
          if (c == CH_QUOTE) scan_state = SCAN_TEXT;
          else add_beat(KIND_NOTSTR, 8'h00);
        end
      end
      SCAN_TEXT: begin
        if (fin) abort_string(KIND_UNTERM);
        else if (c == CH_QUOTE) abort_string(KIND_DONE);
        else if (c < 8'h20) abort_string(KIND_CTRL);
        else if (c == CH_BACKSLASH) scan_state = SCAN_ESCAPE;
        else add_beat(KIND_BYTE, c);
      end
      SCAN_ESCAPE: begin
        if (fin) begin
          abort_string(KIND_UNTERM);
        end else begin
          scan_state = SCAN_TEXT;
          case (c) inside
            CH_QUOTE, CH_BACKSLASH, CH_SLASH: add_beat(KIND_BYTE, c);
            CH_LOWER_B: add_beat(KIND_BYTE, CH_BS);
            CH_LOWER_F: add_beat(KIND_BYTE, CH_FF);
            CH_LOWER_N: add_beat(KIND_BYTE, CH_LF);
            CH_LOWER_R: add_beat(KIND_BYTE, CH_CR);
            CH_LOWER_T: add_beat(KIND_BYTE, CH_TAB);
            CH_LOWER_U: begin
              scan_state = SCAN_HEX_FIRST;
              digit_count = 2'd0;
              hex_accum = 16'h0000;
            end
            default: abort_string(KIND_BADESC);
          endcase
        end
      end
      SCAN_HEX_FIRST, SCAN_HEX_SECOND: begin
        if (fin) abort_string(KIND_UNTERM_HEX);
        else take_hex_digit(c);
      end
      SCAN_WANT_BSL: begin
        if (fin || c != CH_BACKSLASH) abort_string(KIND_LONE);
        else scan_state = SCAN_WANT_U;
      end
      SCAN_WANT_U: begin
        if (fin || c != CH_LOWER_U) begin
          abort_string(KIND_LONE);
        end else begin
          scan_state = SCAN_HEX_SECOND;
          digit_count = 2'd0;
          hex_accum = 16'h0000;
        end
      end
      default: scan_state = SCAN_IDLE;
    endcase
    if (run_beats.size() != 0) begin
      run_beats[run_beats.size() - 1].last_of_run = 1'b1;
      due_beats = {due_beats, run_beats};
    end
  endfunction

  always @(posedge clk) begin : watch
    jsu_result_t want;
    if (rst) begin
      scan_state = SCAN_IDLE;
      digit_count = 2'd0;
      hex_accum = 16'h0000;
      high_bits = 10'd0;
      due_beats.delete();
    end else begin
      if (pop && !empty) begin
        if (due_beats.size() == 0) begin
          $error("unexpected beat: out_byte %02h result_kind %0d last_of_run %0b",
                 result.out_byte, result.result_kind, result.last_of_run);
          fail_count++;
        end else begin
          want = due_beats.pop_front();
          if (result.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, result.out_byte);
            fail_count++;
          end
          if (result.result_kind !== want.result_kind) begin
            $error("result_kind: expected %0d, got %0d", want.result_kind,
                   result.result_kind);
            fail_count++;
          end
          if (result.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                   result.last_of_run);
            fail_count++;
          end
        end
      end
      if (push && !full) decode_text_byte(item);
    end
    beats_owed = due_beats.size();
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the JSON string unescaper testbench: clock, reset, text stimulus and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_LOWER_B   = 8'h62;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_U   = 8'h75;
  localparam int         STALL_LIMIT  = 1000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  jsu_item_t   item = '0;
  logic        pop = 1'b0;
  logic        empty;
  jsu_result_t result;
  int unsigned fail_count;
  int unsigned beats_owed;

  logic        src_idles = 1'b1;
  logic        sink_idles = 1'b1;
  int unsigned hold_request = 0;
  int unsigned stall_cycles = 0;
  jsu_item_t   text_plan[$];

  json_string_unescape i_dut (.*);
  jsu_checker i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("json_string_unescape regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : drain
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= !(sink_idles && $urandom_range(99) < 36);
      end
    end
  end

  function automatic void put_byte(logic [7:0] b);
    jsu_item_t it;
    it.text_byte = b;
    it.text_end  = 1'b0;
    text_plan = {text_plan, it};
  endfunction

  function automatic void put_end();
    jsu_item_t it;
    it.text_byte = 8'($urandom);
    it.text_end  = 1'b1;
    text_plan = {text_plan, it};
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  function automatic logic is_hex_char(logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  function automatic logic [7:0] simple_escape(int n);
    case (n)
      0: return CH_QUOTE;
      1: return CH_BACKSLASH;
      2: return CH_SLASH;
      3: return CH_LOWER_B;
      4: return CH_LOWER_F;
      5: return CH_LOWER_N;
      6: return CH_LOWER_R;
      default: return CH_LOWER_T;
    endcase
  endfunction

  function automatic logic is_escape_letter(logic [7:0] b);
    int i;
    for (i = 0; i < 8; i++) if (b == simple_escape(i)) return 1'b1;
    return b == CH_LOWER_U;
  endfunction

  function automatic void put_unicode_escape(logic [15:0] v);
    int i;
    put_byte(CH_BACKSLASH);
    put_byte(CH_LOWER_U);
    for (i = 3; i >= 0; i--) put_byte(hex_char(v[4*i +: 4]));
  endfunction

  function automatic logic [15:0] plain_code_unit();
    logic [15:0] v;
    case ($urandom_range(3))
      0: v = 16'($urandom_range(16'h007F));
      1: v = 16'($urandom_range(16'h07FF, 16'h0080));
      2: v = 16'($urandom_range(16'hFFFF, 16'h0800));
      default: v = 16'($urandom);
    endcase
    if (v >= 16'hD800 && v <= 16'hDFFF) v = v ^ 16'h8000;
    return v;
  endfunction

  function automatic logic [15:0] high_unit();
    return 16'hD800 + 16'($urandom_range(1023));
  endfunction

  function automatic void add_directed();
    int i;
    put_end();
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(CH_QUOTE);
    put_byte(8'h20);
    put_byte(8'h80);
    put_byte(8'hFF);
    for (i = 0; i < 8; i++) begin
      put_byte(CH_BACKSLASH);
      put_byte(simple_escape(i));
    end
    put_unicode_escape(16'h0000);
    put_unicode_escape(16'h07FF);
    put_unicode_escape(16'hFFFF);
    put_unicode_escape(16'hDBFF);
    put_unicode_escape(16'hDFFF);
    put_byte(CH_QUOTE);
    put_byte(CH_QUOTE);
    put_byte(8'h1F);
    put_byte(CH_QUOTE);
    put_end();
    put_byte(CH_QUOTE);
    put_byte(CH_BACKSLASH);
    put_end();
    put_byte(CH_QUOTE);
    put_byte(CH_BACKSLASH);
    put_byte(8'h78);
    put_byte(CH_QUOTE);
    put_byte(CH_BACKSLASH);
    put_byte(CH_LOWER_U);
    put_byte(8'h41);
    put_end();
    put_byte(CH_QUOTE);
    put_byte(CH_BACKSLASH);
    put_byte(CH_LOWER_U);
    put_byte(8'h67);
    put_byte(CH_QUOTE);
    put_unicode_escape(16'hD800);
    put_byte(8'h41);
    put_byte(CH_QUOTE);
    put_unicode_escape(16'hD800);
    put_end();
    put_byte(CH_QUOTE);
    put_unicode_escape(16'hDC00);
    put_byte(CH_QUOTE);
    put_unicode_escape(16'hD800);
    put_unicode_escape(16'h0041);
  endfunction

  function automatic void add_random_string();
    int          pieces;
    int          ending;
    int          i;
    logic [7:0]  b;
    logic [15:0] v;
    put_byte(CH_QUOTE);
    pieces = $urandom_range(8);
    for (i = 0; i < pieces; i++) begin
      case ($urandom_range(6))
        0, 1, 2, 3: begin
          do b = 8'($urandom_range(255, 32)); while (b == CH_QUOTE || b == CH_BACKSLASH);
          put_byte(b);
        end
        4: begin
          put_byte(CH_BACKSLASH);
          put_byte(simple_escape($urandom_range(7)));
        end
        5: put_unicode_escape(plain_code_unit());
        default: begin
          put_unicode_escape(high_unit());
          put_unicode_escape(16'hDC00 + 16'($urandom_range(1023)));
        end
      endcase
    end
    ending = $urandom_range(19);
    if (ending < 14) begin
      put_byte(CH_QUOTE);
    end else begin
      case (ending)
        14: begin
          if ($urandom_range(1)) put_byte(CH_BACKSLASH);
          put_end();
        end
        15: put_byte(8'($urandom_range(31)));
        16: begin
          put_byte(CH_BACKSLASH);
          do b = 8'($urandom); while (is_escape_letter(b));
          put_byte(b);
        end
        17: begin
          put_byte(CH_BACKSLASH);
          put_byte(CH_LOWER_U);
          repeat ($urandom_range(3)) put_byte(hex_char(4'($urandom)));
          if ($urandom_range(1)) begin
            put_end();
          end else begin
            do b = 8'($urandom); while (is_hex_char(b));
            put_byte(b);
          end
        end
        18: begin
          if ($urandom_range(3) == 0) begin
            put_unicode_escape(16'hDC00 + 16'($urandom_range(1023)));
          end else begin
            put_unicode_escape(high_unit());
            case ($urandom_range(2))
              0: begin
                do b = 8'($urandom); while (b == CH_BACKSLASH);
                put_byte(b);
              end
              1: put_end();
              default: begin
                put_byte(CH_BACKSLASH);
                if ($urandom_range(3) == 0) begin
                  put_end();
                end else begin
                  do b = 8'($urandom); while (b == CH_LOWER_U);
                  put_byte(b);
                end
              end
            endcase
          end
        end
        default: begin
          put_unicode_escape(high_unit());
          do v = 16'($urandom); while (v >= 16'hDC00 && v <= 16'hDFFF);
          put_unicode_escape(v);
        end
      endcase
    end
  endfunction

  function automatic void add_noise();
    repeat ($urandom_range(3, 1)) begin
      if ($urandom_range(4) == 0) put_end();
      else put_byte(8'($urandom));
    end
  endfunction

  function automatic void fill_plan(int target);
    while (text_plan.size() < target) begin
      if ($urandom_range(9) == 0) add_noise();
      else add_random_string();
    end
  endfunction

  task automatic send_plan();
    jsu_item_t next;
    while (text_plan.size() != 0) begin
      next = text_plan.pop_front();
      while (src_idles && $urandom_range(99) < 36) begin
        push <= 1'b0;
        @(negedge clk);
      end
      push <= 1'b1;
      item <= next;
      do @(posedge clk); while (full);
      @(negedge clk);
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    add_directed();
    send_plan();
    push <= 1'b0;
    wait (beats_owed == 0);
    @(negedge clk);
    // The sink holds off while text keeps coming, so the block backs up.
    src_idles = 1'b0;
    hold_request = 120;
    fill_plan(30);
    send_plan();
    sink_idles = 1'b0;
    fill_plan(15);
    send_plan();
    src_idles = 1'b1;
    sink_idles = 1'b1;
    fill_plan(15);
    send_plan();
    push <= 1'b0;
    wait (beats_owed == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("json_string_unescape regression: pass");
    end else begin
      $display("json_string_unescape regression: fail");
    end
    $finish;
  end

endmodule
